@@ rtl/tls_client_hello_detector_macros.svh @@
// Assertion macros for the TLS ClientHello detector.
// Taken by the top level; expects clk_i and rst_ni in scope.
`ifndef TLS_CLIENT_HELLO_DETECTOR_MACROS_SVH
`define TLS_CLIENT_HELLO_DETECTOR_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define TLSCH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form built on the macro above.
`define TLSCH_ASSERT_IMPL(label, ante, cons, msg) \
  `TLSCH_ASSERT(label, (ante) |-> (cons), msg)

`endif

@@ rtl/tlsch_pkg.sv @@
// Shared types and constants of the TLS ClientHello detector.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package tlsch_pkg;

  localparam logic [1:0]  FAM_IPV4          = 2'd0;
  localparam logic [1:0]  FAM_IPV6          = 2'd1;
  localparam logic [15:0] PORT_RESET        = 16'd443;
  localparam logic [7:0]  PROTO_TCP         = 8'd6;
  localparam logic [7:0]  CONTENT_HANDSHAKE = 8'd22;
  localparam logic [7:0]  HS_CLIENT_HELLO   = 8'd1;
  localparam logic [15:0] RECORD_HDR_LEN    = 16'd5;
  localparam logic [7:0]  VER_MAJOR_TLS     = 8'h03;
  localparam logic [7:0]  VER_MINOR_LOW     = 8'h01;
  localparam logic [7:0]  VER_MINOR_HIGH    = 8'h03;
  localparam logic [15:0] IPV4_MIN_HDR      = 16'd20;
  localparam logic [15:0] IPV6_HDR          = 16'd40;
  localparam logic [5:0]  IPV6_HDR_NARROW   = 6'd40;
  localparam logic [15:0] TCP_MIN_HDR       = 16'd20;
  localparam logic [15:0] TCP_OFFSET_POS    = 16'd12;
  localparam logic [15:0] IPV4_PROTO_POS    = 16'd9;
  localparam logic [15:0] IPV6_PROTO_POS    = 16'd6;
  localparam logic [3:0]  TCP_MIN_WORDS     = 4'd5;
  localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
  localparam int unsigned QUEUE_DEPTH       = 4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [1:0]  address_family;
    logic        socket_present;
    logic [15:0] dest_port;
  } in_t;

  typedef struct packed {
    logic        client_hello;
    logic [15:0] payload_length;
    logic [7:0]  legacy_minor_version;
  } out_t;

  // Everything the back end needs to judge one finished packet.
  typedef struct packed {
    logic [15:0] byte_count;
    logic [6:0]  payload_start;
    logic [5:0]  tcp_start;
    logic [1:0]  family;
    logic        port_matches;
    logic        offset_valid;
    logic [7:0]  protocol;
    logic [7:0]  rec_type;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [15:0] record_length;
    logic [7:0]  hello_type;
  } summary_t;

endpackage

@@ rtl/tlsch_front.sv @@
// Front end: walks the packet bytes and captures header fields.
// Depends on tlsch_pkg; pushes one summary word per packet.
`timescale 1ns / 1ps
module tlsch_front
  import tlsch_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  in_t         in_i,
  input  logic [15:0] match_port_i,
  output logic        sum_valid_o,
  output summary_t    sum_o
);

  logic [15:0] cnt_q, cnt_d;
  logic [6:0]  pstart_q, pstart_d;
  logic [5:0]  tcp_q, tcp_d;
  logic [1:0]  fam_q, fam_d;
  logic        port_q, port_d;
  logic        ov_q, ov_d;
  logic [7:0]  proto_q, proto_d;
  logic [7:0]  content_q, content_d;
  logic [7:0]  major_q, major_d;
  logic [7:0]  minor_q, minor_d;
  logic [15:0] reclen_q, reclen_d;
  logic [7:0]  htype_q, htype_d;
  logic [15:0] rel;
  logic [7:0]  b;

  assign b = in_i.data_byte;

  always_comb begin
    cnt_d     = cnt_q;
    pstart_d  = pstart_q;
    tcp_d     = tcp_q;
    fam_d     = fam_q;
    port_d    = port_q;
    ov_d      = ov_q;
    proto_d   = proto_q;
    content_d = content_q;
    major_d   = major_q;
    minor_d   = minor_q;
    reclen_d  = reclen_q;
    htype_d   = htype_q;
    rel       = cnt_q - 16'(pstart_q);

    // Sideband is sampled on the first byte only.
    if (cnt_q == '0) begin
      fam_d  = in_i.address_family;
      port_d = in_i.socket_present && (in_i.dest_port == match_port_i);
      if (fam_d == FAM_IPV4) begin
        tcp_d = {b[3:0], 2'b00};
      end else if (fam_d == FAM_IPV6) begin
        tcp_d = IPV6_HDR_NARROW;
      end else begin
        tcp_d = '0;
      end
    end

    if (!fam_d[1]) begin
      if ((fam_d == FAM_IPV4 && cnt_q == IPV4_PROTO_POS) ||
          (fam_d == FAM_IPV6 && cnt_q == IPV6_PROTO_POS)) begin
        proto_d = b;
      end
      if (cnt_q == 16'(tcp_d) + TCP_OFFSET_POS && b[7:4] >= TCP_MIN_WORDS) begin
        pstart_d = 7'({1'b0, tcp_d}) + 7'({b[7:4], 2'b00});
        ov_d     = 1'b1;
      end
      rel = cnt_q - 16'(pstart_d);
      if (ov_d && cnt_q >= 16'(pstart_d)) begin
        case (rel)
          16'd0:   content_d = b;
          16'd1:   major_d   = b;
          16'd2:   minor_d   = b;
          16'd3:   reclen_d  = {b, reclen_q[7:0]};
          16'd4:   reclen_d  = {reclen_q[15:8], b};
          16'd5:   htype_d   = b;
          default: ;
        endcase
      end
    end

    if (cnt_q != COUNT_MAX) begin
      cnt_d = cnt_q + 16'd1;
    end
  end

  always_comb begin
    sum_valid_o         = accept_i && in_i.last_byte;
    sum_o.byte_count    = cnt_d;
    sum_o.payload_start = pstart_d;
    sum_o.tcp_start     = tcp_d;
    sum_o.family        = fam_d;
    sum_o.port_matches  = port_d;
    sum_o.offset_valid  = ov_d;
    sum_o.protocol      = proto_d;
    sum_o.rec_type      = content_d;
    sum_o.version_major = major_d;
    sum_o.version_minor = minor_d;
    sum_o.record_length = reclen_d;
    sum_o.hello_type    = htype_d;
  end

  // Per-packet state returns to zero after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pstart_q  <= '0;
      tcp_q     <= '0;
      fam_q     <= '0;
      port_q    <= 1'b0;
      ov_q      <= 1'b0;
      proto_q   <= '0;
      content_q <= '0;
      major_q   <= '0;
      minor_q   <= '0;
      reclen_q  <= '0;
      htype_q   <= '0;
    end else if (accept_i && in_i.last_byte) begin
      cnt_q     <= '0;
      pstart_q  <= '0;
      tcp_q     <= '0;
      fam_q     <= '0;
      port_q    <= 1'b0;
      ov_q      <= 1'b0;
      proto_q   <= '0;
      content_q <= '0;
      major_q   <= '0;
      minor_q   <= '0;
      reclen_q  <= '0;
      htype_q   <= '0;
    end else if (accept_i) begin
      cnt_q     <= cnt_d;
      pstart_q  <= pstart_d;
      tcp_q     <= tcp_d;
      fam_q     <= fam_d;
      port_q    <= port_d;
      ov_q      <= ov_d;
      proto_q   <= proto_d;
      content_q <= content_d;
      major_q   <= major_d;
      minor_q   <= minor_d;
      reclen_q  <= reclen_d;
      htype_q   <= htype_d;
    end
  end

endmodule

@@ rtl/tlsch_fifo.sv @@
// Short queue of packet summaries between front and back end.
// Depends on tlsch_pkg for the summary type.
`timescale 1ns / 1ps
module tlsch_fifo
  import tlsch_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  input  summary_t wr_data_i,
  output logic     full_o,
  input  logic     rd_ready_i,
  output summary_t rd_data_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  summary_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_valid_i && !full_o;
  assign do_rd     = rd_ready_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/tlsch_back.sv @@
// Back end: judges one packet summary and holds the result word.
// Depends on tlsch_pkg for the summary and result types.
`timescale 1ns / 1ps
module tlsch_back
  import tlsch_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     sum_valid_i,
  input  summary_t sum_i,
  output logic     sum_ready_o,
  input  logic     pop_i,
  output logic     empty_o,
  output out_t     out_o
);

  logic        out_valid_q;
  out_t        out_q, res;
  logic        fam_ok, hdr_ok, ver_ok;
  logic [15:0] plen;
  logic [16:0] rec_end;

  always_comb begin
    if (sum_i.family == FAM_IPV4) begin
      fam_ok = sum_i.byte_count >= IPV4_MIN_HDR;
    end else if (sum_i.family == FAM_IPV6) begin
      fam_ok = sum_i.byte_count >= IPV6_HDR;
    end else begin
      fam_ok = 1'b0;
    end
    hdr_ok = fam_ok && sum_i.protocol == PROTO_TCP && sum_i.offset_valid &&
             sum_i.byte_count >= 16'(sum_i.tcp_start) + TCP_MIN_HDR &&
             sum_i.byte_count >= 16'(sum_i.payload_start);
    plen    = sum_i.byte_count - 16'(sum_i.payload_start);
    rec_end = 17'(sum_i.record_length) + 17'(RECORD_HDR_LEN);
    ver_ok  = sum_i.version_major == VER_MAJOR_TLS &&
              sum_i.version_minor >= VER_MINOR_LOW &&
              sum_i.version_minor <= VER_MINOR_HIGH;
    res.client_hello = hdr_ok && sum_i.port_matches &&
                       plen > RECORD_HDR_LEN &&
                       sum_i.rec_type == CONTENT_HANDSHAKE &&
                       sum_i.hello_type == HS_CLIENT_HELLO &&
                       rec_end <= 17'(plen) && ver_ok;
    res.payload_length       = hdr_ok ? plen : '0;
    res.legacy_minor_version = sum_i.version_minor;
  end

  // A new summary is taken whenever the result register is free or being read.
  assign sum_ready_o = !out_valid_q || pop_i;
  assign empty_o     = !out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (sum_valid_i && sum_ready_o) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_ready_o) begin
      out_valid_q <= sum_valid_i;
    end
  end

endmodule

@@ rtl/tls_client_hello_detector.sv @@
// Channel   Handshake            Payload
// input     push / full          in_i (in_t): one packet byte plus sideband
// result    empty / pop          out_o (out_t): one verdict per packet
// config    cfg_valid_i / _ready cfg_data_i: destination port to examine
//
// One byte is accepted per cycle, back to back while full is low. A verdict
// reaches the result ports when its summary, which enters the queue at the
// edge that takes the last byte, moves on to the result register once that
// register is free or being popped. full rises only when the queue of
// finished packets is full because results are not being popped. Reset
// restores port 443 and clears the packet state.
`timescale 1ns / 1ps
`include "tls_client_hello_detector_macros.svh"
module tls_client_hello_detector
  import tlsch_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_t         in_i,
  output logic        empty,
  input  logic        pop,
  output out_t        out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] match_port_q;
  logic        accept;
  logic        sum_valid, q_full, q_empty, back_ready;
  summary_t    sum_front, sum_head;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_port_q <= PORT_RESET;
    end else if (cfg_valid_i) begin
      match_port_q <= cfg_data_i;
    end
  end

  tlsch_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_i         (in_i),
    .match_port_i (match_port_q),
    .sum_valid_o  (sum_valid),
    .sum_o        (sum_front)
  );

  tlsch_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (sum_valid),
    .wr_data_i  (sum_front),
    .full_o     (q_full),
    .rd_ready_i (back_ready),
    .rd_data_o  (sum_head),
    .empty_o    (q_empty)
  );

  tlsch_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (!q_empty),
    .sum_i       (sum_head),
    .sum_ready_o (back_ready),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_o       (out_o)
  );

  `TLSCH_ASSERT(a_queue_drains, (!q_empty && empty) |=> !empty, "waiting summary not moved to output")
  `TLSCH_ASSERT_IMPL(a_hello_len, !empty && out_o.client_hello, out_o.payload_length > RECORD_HDR_LEN, "hello with short payload")
  `TLSCH_ASSERT_IMPL(a_hello_ver, !empty && out_o.client_hello, out_o.legacy_minor_version >= VER_MINOR_LOW && out_o.legacy_minor_version <= VER_MINOR_HIGH, "hello with bad version")

endmodule

@@ tb/tls_client_hello_detector_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for tls_client_hello_detector: builds IPv4, IPv6 and other-family packets byte by
// byte, predicts the verdict of each packet and checks every word on the result queue.
// Depends on tlsch_pkg and the detector RTL only.
module tls_client_hello_detector_tb;
  import tlsch_pkg::*;

  localparam int unsigned HALF_PERIOD    = 5;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned LIMIT_CYCLES   = 200_000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned MAX_REPORTS    = 40;
  localparam int unsigned ITEM_TARGET    = 450;
  localparam int unsigned PHASE_PACKETS  = 4;
  localparam logic [1:0]  FAM_OTHER      = 2'd2;
  localparam logic [7:0]  IPV4_VER_NIB   = 8'h40;
  localparam logic [7:0]  IPV6_VER_BYTE  = 8'h60;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  // Recipe for one packet; trunc of zero keeps the natural length.
  typedef struct {
    logic [1:0]  fam;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [3:0]  words;
    logic [7:0]  content;
    logic [7:0]  major;
    logic [7:0]  minor;
    logic [7:0]  htype;
    logic [15:0] rec_len;
    int unsigned pay_len;
    int unsigned trunc;
    logic        sock;
    logic [15:0] port;
  } pkt_spec_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic        full;
  in_t         in_word   = '0;
  logic        empty;
  logic        pop       = 1'b0;
  out_t        out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  tls_client_hello_detector DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Shadow of the detector: port register plus the per-packet capture state.
  logic [15:0] port_cfg = PORT_RESET;
  logic [15:0] pk_count;
  logic [15:0] pk_rec_len;
  int unsigned pk_pay_start;
  int unsigned pk_tcp_start;
  logic [1:0]  pk_family;
  logic        pk_port_hit;
  logic        pk_off_ok;
  logic [7:0]  pk_proto;
  logic [7:0]  pk_content;
  logic [7:0]  pk_major;
  logic [7:0]  pk_minor;
  logic [7:0]  pk_htype;
  out_t        verdict_q[$];
  logic [7:0]  pkt_bytes[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;
  int unsigned burst_left  = 0;
  bit          hold_req    = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned rx_left     = 0;
  rx_mode_e    rx_mode     = RX_STREAM;

  function automatic void forget_packet();
    pk_count     = '0;
    pk_pay_start = 0;
    pk_tcp_start = 0;
    pk_family    = '0;
    pk_port_hit  = 1'b0;
    pk_off_ok    = 1'b0;
    pk_proto     = '0;
    pk_content   = '0;
    pk_major     = '0;
    pk_minor     = '0;
    pk_rec_len   = '0;
    pk_htype     = '0;
  endfunction

  // Advances the shadow by one accepted byte; returns 1 with the verdict on a last byte.
  function automatic bit judge_byte(input in_t w, output out_t v);
    int unsigned pos;
    int unsigned n;
    int unsigned plen;
    int unsigned rlen;
    bit          hdr_ok;
    v = '0;
    pos = 32'(pk_count);
    if (pos == 0) begin
      pk_family   = w.address_family;
      pk_port_hit = w.socket_present && (w.dest_port == port_cfg);
      if (pk_family == FAM_IPV4) begin
        pk_tcp_start = 32'(w.data_byte[3:0]) * 4;
      end else if (pk_family == FAM_IPV6) begin
        pk_tcp_start = 32'(IPV6_HDR);
      end else begin
        pk_tcp_start = 0;
      end
    end
    if (pk_family == FAM_IPV4 || pk_family == FAM_IPV6) begin
      if ((pk_family == FAM_IPV4 && pos == IPV4_PROTO_POS) ||
          (pk_family == FAM_IPV6 && pos == IPV6_PROTO_POS)) begin
        pk_proto = w.data_byte;
      end
      if (pos == pk_tcp_start + TCP_OFFSET_POS && w.data_byte[7:4] >= TCP_MIN_WORDS) begin
        pk_pay_start = pk_tcp_start + 32'(w.data_byte[7:4]) * 4;
        pk_off_ok    = 1'b1;
      end
      // The record header and the handshake type sit at fixed payload offsets.
      if (pk_off_ok && pos >= pk_pay_start) begin
        case (pos - pk_pay_start)
          0: pk_content = w.data_byte;
          1: pk_major = w.data_byte;
          2: pk_minor = w.data_byte;
          3: pk_rec_len[15:8] = w.data_byte;
          4: pk_rec_len[7:0] = w.data_byte;
          5: pk_htype = w.data_byte;
          default: ;
        endcase
      end
    end
    if (pk_count != COUNT_MAX) pk_count++;
    if (!w.last_byte) return 1'b0;

    n = 32'(pk_count);
    hdr_ok = (pk_family == FAM_IPV4 && n >= IPV4_MIN_HDR) ||
             (pk_family == FAM_IPV6 && n >= IPV6_HDR);
    hdr_ok = hdr_ok && pk_proto == PROTO_TCP && n >= pk_tcp_start + TCP_MIN_HDR &&
             pk_off_ok && n >= pk_pay_start;
    if (hdr_ok) begin
      plen = n - pk_pay_start;
      rlen = 32'(pk_rec_len);
      v.payload_length = plen[15:0];
      v.client_hello = pk_port_hit && plen >= RECORD_HDR_LEN + 1 &&
                       pk_content == CONTENT_HANDSHAKE && pk_htype == HS_CLIENT_HELLO &&
                       rlen + RECORD_HDR_LEN <= plen && pk_major == VER_MAJOR_TLS &&
                       pk_minor >= VER_MINOR_LOW && pk_minor <= VER_MINOR_HIGH;
    end
    v.legacy_minor_version = pk_minor;
    forget_packet();
    return 1'b1;
  endfunction

  function automatic void put_byte(input int unsigned idx, input logic [7:0] val);
    if (idx < pkt_bytes.size()) pkt_bytes[idx] = val;
  endfunction

  // Lays out the packet over random filler; later fields win where headers overlap.
  function automatic void build_bytes(input pkt_spec_t s);
    int unsigned tcp;
    int unsigned pay;
    int unsigned len;
    if (s.fam == FAM_IPV4) begin
      tcp = 32'(s.ihl) * 4;
    end else if (s.fam == FAM_IPV6) begin
      tcp = 32'(IPV6_HDR);
    end else begin
      tcp = 32'(IPV4_MIN_HDR);
    end
    pay = tcp + 32'(s.words) * 4;
    len = (s.trunc != 0) ? s.trunc : pay + s.pay_len;
    if (len == 0) len = 1;
    pkt_bytes.delete();
    repeat (len) pkt_bytes.push_back(8'($urandom));
    if (s.fam == FAM_IPV4) begin
      put_byte(0, IPV4_VER_NIB | {4'd0, s.ihl});
      put_byte(32'(IPV4_PROTO_POS), s.proto);
    end else if (s.fam == FAM_IPV6) begin
      put_byte(0, IPV6_VER_BYTE);
      put_byte(32'(IPV6_PROTO_POS), s.proto);
    end
    put_byte(tcp + TCP_OFFSET_POS, {s.words, 4'($urandom)});
    put_byte(pay, s.content);
    put_byte(pay + 1, s.major);
    put_byte(pay + 2, s.minor);
    put_byte(pay + 3, s.rec_len[15:8]);
    put_byte(pay + 4, s.rec_len[7:0]);
    put_byte(pay + 5, s.htype);
  endfunction

  // An IHL of zero folds the TCP header onto the IP header, which keeps packets short.
  function automatic pkt_spec_t hello_spec(input logic [1:0] fam, input int unsigned pay_len);
    pkt_spec_t s;
    s.fam     = fam;
    s.ihl     = 4'd0;
    s.proto   = PROTO_TCP;
    s.words   = TCP_MIN_WORDS;
    s.content = CONTENT_HANDSHAKE;
    s.major   = VER_MAJOR_TLS;
    s.minor   = VER_MINOR_HIGH;
    s.htype   = HS_CLIENT_HELLO;
    s.rec_len = (pay_len >= RECORD_HDR_LEN) ? 16'(pay_len - RECORD_HDR_LEN) : 16'd0;
    s.pay_len = pay_len;
    s.trunc   = 0;
    s.sock    = 1'b1;
    s.port    = port_cfg;
    return s;
  endfunction

  // Mostly plausible handshakes with a field or two bent; a quarter is pure noise.
  function automatic pkt_spec_t random_spec();
    pkt_spec_t   s;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    s = hello_spec((pick < 6) ? FAM_IPV4 : ((pick < 9) ? FAM_IPV6 : 2'($urandom_range(2, 3))),
                   $urandom_range(0, 12));
    if ($urandom_range(0, 3) == 0) begin
      s.fam     = 2'($urandom);
      s.ihl     = 4'($urandom);
      s.proto   = 8'($urandom);
      s.words   = 4'($urandom);
      s.content = 8'($urandom);
      s.major   = 8'($urandom);
      s.minor   = 8'($urandom);
      s.htype   = 8'($urandom);
      s.rec_len = 16'($urandom);
      s.sock    = 1'($urandom);
      s.port    = 16'($urandom);
      s.trunc   = $urandom_range(1, 40);
      return s;
    end
    s.ihl = ($urandom_range(0, 1) == 0) ? 4'd5 : 4'd0;
    if ($urandom_range(0, 9) == 0) s.ihl = 4'($urandom);
    if ($urandom_range(0, 9) == 0) s.proto = 8'($urandom);
    s.words = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) s.content = 8'($urandom);
    if ($urandom_range(0, 9) == 0) s.major = 8'($urandom);
    if ($urandom_range(0, 6) == 0) s.htype = 8'($urandom);
    s.minor = 8'($urandom_range(0, 4));
    s.rec_len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, s.pay_len + 2));
    if ($urandom_range(0, 9) == 0) s.sock = 1'b0;
    if ($urandom_range(0, 6) == 0) s.port = 16'($urandom);
    if ($urandom_range(0, 9) == 0) s.trunc = $urandom_range(1, 40);
    return s;
  endfunction

  // Offers one word and returns at the edge that takes it.
  task automatic push_word(input in_t w);
    out_t v;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
    end
    burst_left--;
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_count++;
    if (judge_byte(w, v)) verdict_q.push_back(v);
  endtask

  // Sideband only counts on the first byte, so it is scrambled on the others.
  task automatic send_packet(input pkt_spec_t s);
    in_t w;
    build_bytes(s);
    foreach (pkt_bytes[i]) begin
      w.data_byte = pkt_bytes[i];
      w.last_byte = (i == pkt_bytes.size() - 1);
      if (i == 0) begin
        w.address_family = s.fam;
        w.socket_present = s.sock;
        w.dest_port      = s.port;
      end else begin
        w.address_family = 2'($urandom);
        w.socket_present = 1'($urandom);
        w.dest_port      = 16'($urandom);
      end
      push_word(w);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_port(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    port_cfg = value;
  endtask

  task automatic test_reset_port();
    pkt_spec_t s;
    s = hello_spec(FAM_IPV4, 32'(RECORD_HDR_LEN) + 1);
    send_packet(s);
    s = hello_spec(FAM_IPV6, 32'(RECORD_HDR_LEN) + 1);
    s.minor = VER_MINOR_LOW;
    send_packet(s);
    s = hello_spec(FAM_IPV4, 32'(RECORD_HDR_LEN) + 1);
    s.port = PORT_RESET + 16'd1;
    send_packet(s);
  endtask

  task automatic test_record_fields();
    pkt_spec_t s;
    s = hello_spec(FAM_IPV4, 32'(RECORD_HDR_LEN) + 1);
    s.minor = 8'd0;
    send_packet(s);
    s = hello_spec(FAM_IPV4, 32'(RECORD_HDR_LEN) + 1);
    s.htype = HS_CLIENT_HELLO + 8'd1;
    send_packet(s);
    // Record one byte longer than the payload carries.
    s = hello_spec(FAM_IPV4, 32'(RECORD_HDR_LEN) + 1);
    s.rec_len = s.rec_len + 16'd1;
    send_packet(s);
    // One byte short of the shortest payload that can hold a hello.
    s = hello_spec(FAM_IPV4, 32'(RECORD_HDR_LEN));
    send_packet(s);
  endtask

  task automatic test_malformed_headers();
    pkt_spec_t s;
    s = hello_spec(FAM_OTHER, 32'(RECORD_HDR_LEN) + 1);
    s.trunc = 8;
    send_packet(s);
    s = hello_spec(FAM_IPV4, 32'(RECORD_HDR_LEN) + 1);
    s.words = TCP_MIN_WORDS - 4'd1;
    send_packet(s);
    s = hello_spec(FAM_IPV4, 32'(RECORD_HDR_LEN) + 1);
    s.trunc = 1;
    send_packet(s);
    s.trunc = 32'(IPV4_MIN_HDR) - 1;
    send_packet(s);
  endtask

  task automatic test_port_register();
    wait_idle();
    write_port(16'h0000);
    send_packet(hello_spec(FAM_IPV4, 32'(RECORD_HDR_LEN) + 1));
    wait_idle();
    write_port(16'hFFFF);
    send_packet(hello_spec(FAM_IPV4, 32'(RECORD_HDR_LEN) + 1));
  endtask

  // The receiver holds off while short packets keep coming, so the result queue fills.
  task automatic test_backpressure();
    pkt_spec_t s;
    wait_idle();
    hold_req = 1'b1;
    for (int i = 0; i < 10; i++) begin
      s = hello_spec(FAM_IPV4, 32'(RECORD_HDR_LEN) + 1);
      if (i != 0) s.trunc = 1;
      send_packet(s);
    end
  endtask

  task automatic test_random();
    int unsigned n_pkts;
    n_pkts = 0;
    while (sent_count < ITEM_TARGET) begin
      if (n_pkts % PHASE_PACKETS == 0) begin
        wait_idle();
        write_port(($urandom_range(0, 2) == 0) ? PORT_RESET : 16'($urandom));
      end
      send_packet(random_spec());
      n_pkts++;
    end
  endtask

  // Result side: pop follows a changing stall pattern, or stays low during a hold-off.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STREAM: pop <= 1'b1;
        RX_COIN:   pop <= 1'($urandom);
        RX_SPARSE: pop <= ($urandom_range(0, 5) == 0);
        default:   pop <= rx_left[0];
      endcase
    end
  end

  always @(posedge clk_i) begin : check_verdict
    out_t want;
    if (rst_ni && pop && !empty) begin
      if (verdict_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: unexpected word hello=%0b length=%0d minor=%0d, none expected",
                   $time, out_word.client_hello, out_word.payload_length,
                   out_word.legacy_minor_version);
        end
      end else begin
        want = verdict_q.pop_front();
        if (out_word.client_hello !== want.client_hello ||
            out_word.payload_length !== want.payload_length ||
            out_word.legacy_minor_version !== want.legacy_minor_version) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: expected hello=%0b length=%0d minor=%0d, got hello=%0b length=%0d minor=%0d",
                     $time, want.client_hello, want.payload_length, want.legacy_minor_version,
                     out_word.client_hello, out_word.payload_length,
                     out_word.legacy_minor_version);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tls_client_hello_detector verification failed");
      $finish;
    end
  end

  initial begin
    forget_packet();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_port();
    test_record_fields();
    test_malformed_headers();
    test_port_register();
    test_backpressure();
    test_random();
    wait_idle();
    if (fail_count == 0) begin
      $display("tls_client_hello_detector verification clean");
    end else begin
      $display("tls_client_hello_detector verification failed");
    end
    $finish;
  end

endmodule
